// ===== sv/can_raf_pkg.sv =====
`timescale 1ns / 1ps

package can_raf_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ID_W        = 11;
    localparam int KEY_W       = ID_W + 1;
    localparam int IDX_W       = 5;
    localparam int EIU_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 11;

    // stored entry: 12-bit key (RTR at the top), 11-bit mask
    localparam int ENTRY_W     = KEY_W + ID_W;

    localparam logic [EIU_W-1:0] EIU_RESET  = EIU_W'(32);
    localparam logic [ID_W-1:0]  BOOT_RESET = ID_W'(12'h03C);

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BOOTLOADER_IDENT = CFG_IDX_W'(1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [STATUS_W-1:0] ST_WRITTEN          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MATCH_HANDLER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH_NO_HANDLER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH         = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXTENDED         = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BOOTLOADER       = 3'd6;

    typedef struct packed {
        logic load;
        logic decide;
        logic search;
        logic post;
    } raf_cmd_t;

    typedef struct packed {
        logic decide_done;
        logic search_done;
        logic out_free;
    } raf_sts_t;

endpackage

// ===== sv/can_raf_ram.sv =====
`timescale 1ns / 1ps

module can_raf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/can_raf_ctrl.sv =====
`timescale 1ns / 1ps

module can_raf_ctrl
    import can_raf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  raf_sts_t sts,
    output raf_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_POST   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.decide_done ? S_POST : S_SEARCH;
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.search_done) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                // hold the result until the output register frees up
                cmd.post = 1'b1;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/can_raf_dp.sv =====
`timescale 1ns / 1ps

module can_raf_dp
    import can_raf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  raf_cmd_t              cmd,
    output raf_sts_t              sts,
    input  logic                  s_cmd,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic [ID_W-1:0]       s_filter_ident,
    input  logic [ID_W-1:0]       s_filter_mask,
    input  logic                  s_filter_rtr,
    input  logic [ID_W-1:0]       s_frame_ident,
    input  logic                  s_frame_rtr,
    input  logic                  s_frame_extended,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [IDX_W-1:0]      m_matched_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [EIU_W-1:0] eiu_reg;
    logic [ID_W-1:0]  boot_reg;

    // captured item
    logic             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [ID_W-1:0]  fil_id_reg;
    logic [ID_W-1:0]  fil_mask_reg;
    logic             fil_rtr_reg;
    logic [ID_W-1:0]  frm_id_reg;
    logic             frm_rtr_reg;
    logic             frm_ext_reg;

    // table
    logic [MAX_ENTRIES-1:0] entry_vld_reg;
    logic [ADDR_W-1:0]      ptr_reg;
    logic [ADDR_W-1:0]      cur_idx_reg;
    logic                   rd_vld_reg;
    logic                   vld_rd_reg;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   ram_we;

    // pending result and output register
    logic [STATUS_W-1:0] pend_status_reg;
    logic [IDX_W-1:0]    pend_index_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [IDX_W-1:0]    m_index_reg;

    logic [CNT_W-1:0]    n_active;
    logic                bad_index;
    logic                is_boot;
    logic                decide_done;
    logic [STATUS_W-1:0] decide_status;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    ent_ident;
    logic [KEY_W-1:0]    ent_mask;
    logic                hit;
    logic                last;
    logic                search_done;
    logic                out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eiu_reg  <= EIU_RESET;
            boot_reg <= BOOT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ENTRIES_IN_USE) begin
                eiu_reg <= cfg_data[EIU_W-1:0];
            end else if (cfg_index == CFG_BOOTLOADER_IDENT) begin
                boot_reg <= cfg_data[ID_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg      <= s_cmd;
            idx_reg      <= s_entry_index;
            fil_id_reg   <= s_filter_ident;
            fil_mask_reg <= s_filter_mask;
            fil_rtr_reg  <= s_filter_rtr;
            frm_id_reg   <= s_frame_ident;
            frm_rtr_reg  <= s_frame_rtr;
            frm_ext_reg  <= s_frame_extended;
        end
    end

    // saturate the entry count to the table depth
    assign n_active  = (CNT_W'(eiu_reg) > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                                 : CNT_W'(eiu_reg);
    assign bad_index = CNT_W'(idx_reg) >= n_active;
    assign is_boot   = frm_id_reg == boot_reg;

    assign decide_done = (cmd_reg == CMD_WRITE) || frm_ext_reg || is_boot
                         || (n_active == '0);

    always_comb begin
        priority if (cmd_reg == CMD_WRITE) begin
            decide_status = bad_index ? ST_BAD_INDEX : ST_WRITTEN;
        end else if (frm_ext_reg) begin
            decide_status = ST_EXTENDED;
        end else if (is_boot) begin
            decide_status = ST_BOOTLOADER;
        end else begin
            decide_status = ST_NO_MATCH;
        end
    end

    assign ram_we = cmd.decide && (cmd_reg == CMD_WRITE) && !bad_index;

    can_raf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata ({fil_rtr_reg, fil_id_reg, fil_mask_reg}),
        .raddr (ptr_reg),
        .rdata (rd_data)
    );

    // a written entry always has a handler, so its valid bit doubles as the mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_vld_reg <= '0;
        end else if (ram_we) begin
            entry_vld_reg[idx_reg[ADDR_W-1:0]] <= 1'b1;
        end
    end

    // one read in flight: compare the entry at cur_idx while the next one is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.search && !search_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            ptr_reg <= '0;
        end else if (cmd.search) begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
        cur_idx_reg <= ptr_reg;
        vld_rd_reg  <= entry_vld_reg[ptr_reg];
    end

    assign key       = {frm_rtr_reg, frm_id_reg};
    assign ent_ident = vld_rd_reg ? rd_data[ENTRY_W-1:ID_W] : '0;
    assign ent_mask  = vld_rd_reg ? {1'b1, rd_data[ID_W-1:0]} : '1;
    assign hit       = ((key ^ ent_ident) & ent_mask) == '0;
    assign last      = (CNT_W'(cur_idx_reg) + CNT_W'(1)) == n_active;

    assign search_done = cmd.search && rd_vld_reg && (hit || last);

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            pend_status_reg <= decide_status;
            pend_index_reg  <= '0;
        end else if (search_done) begin
            if (hit) begin
                pend_status_reg <= vld_rd_reg ? ST_MATCH_HANDLER : ST_MATCH_NO_HANDLER;
                pend_index_reg  <= IDX_W'(cur_idx_reg);
            end else begin
                pend_status_reg <= ST_NO_MATCH;
                pend_index_reg  <= '0;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.post && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post && out_free) begin
            m_status_reg <= pend_status_reg;
            m_index_reg  <= pend_index_reg;
        end
    end

    assign sts.decide_done = decide_done;
    assign sts.search_done = search_done;
    assign sts.out_free    = out_free;

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_matched_index = m_index_reg;

endmodule

// ===== sv/can_rx_acceptance_filter_core.sv =====
`timescale 1ns / 1ps

// Acceptance filter for standard CAN frames, 32-entry identifier/mask table.
// Input beat (s_valid/s_ready): s_cmd selects a filter write (entry_index,
// filter_ident, filter_mask, filter_rtr) or a received frame (frame_ident,
// frame_rtr, frame_extended). Every input beat gives exactly one result beat
// (m_valid/m_ready) carrying m_status and m_matched_index.
// Configuration beats (cfg_valid/cfg_ready, always ready): index 0 sets the
// entries in use, index 1 the bootloader identifier; other indexes are dropped.
// Writes, extended, bootloader and empty-table frames skip the table search;
// a table search walks the single RAM read port one entry a cycle and stops
// at the first hit or at the last of the entries in use. s_ready rises at
// the edge that loads the result into the output register, so a new item is
// taken only once the previous result has been loaded there.
// Reset: every entry reads as identifier 0, mask all ones, no handler;
// entries in use = 32, bootloader identifier = 0x3C. No clearing pass.
// Stall: a result waits in the output register while the next item is
// accepted and processed; that item's result is held until m_ready frees it.
module can_rx_acceptance_filter_core
    import can_raf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic [ID_W-1:0]       s_filter_ident,
    input  logic [ID_W-1:0]       s_filter_mask,
    input  logic                  s_filter_rtr,
    input  logic [ID_W-1:0]       s_frame_ident,
    input  logic                  s_frame_rtr,
    input  logic                  s_frame_extended,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [IDX_W-1:0]      m_matched_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    raf_cmd_t cmd;
    raf_sts_t sts;

    can_raf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    can_raf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_cmd            (s_cmd),
        .s_entry_index    (s_entry_index),
        .s_filter_ident   (s_filter_ident),
        .s_filter_mask    (s_filter_mask),
        .s_filter_rtr     (s_filter_rtr),
        .s_frame_ident    (s_frame_ident),
        .s_frame_rtr      (s_frame_rtr),
        .s_frame_extended (s_frame_extended),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_matched_index  (m_matched_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule

// ===== tb/tb_can_rx_acceptance_filter_core.sv =====
`timescale 1ns / 1ps

module tb_can_rx_acceptance_filter_core;
    import can_raf_pkg::*;

    typedef struct {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [ID_W-1:0]   filter_ident;
        logic [ID_W-1:0]   filter_mask;
        logic              filter_rtr;
        logic [ID_W-1:0]   frame_ident;
        logic              frame_rtr;
        logic              frame_extended;
    } filt_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
    } filt_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = CMD_WRITE;
    logic [IDX_W-1:0]      s_entry_index = '0;
    logic [ID_W-1:0]       s_filter_ident = '0;
    logic [ID_W-1:0]       s_filter_mask = '0;
    logic                  s_filter_rtr = 1'b0;
    logic [ID_W-1:0]       s_frame_ident = '0;
    logic                  s_frame_rtr = 1'b0;
    logic                  s_frame_extended = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [IDX_W-1:0]      m_matched_index;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    can_rx_acceptance_filter_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_entry_index    (s_entry_index),
        .s_filter_ident   (s_filter_ident),
        .s_filter_mask    (s_filter_mask),
        .s_filter_rtr     (s_filter_rtr),
        .s_frame_ident    (s_frame_ident),
        .s_frame_rtr      (s_frame_rtr),
        .s_frame_extended (s_frame_extended),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_matched_index  (m_matched_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // filter table and registers as the block should hold them
    logic [KEY_W-1:0]  tbl_key [MAX_ENTRIES];
    logic [KEY_W-1:0]  tbl_mask [MAX_ENTRIES];
    logic              tbl_handler [MAX_ENTRIES];
    logic [EIU_W-1:0]  entries_cfg = EIU_RESET;
    logic [ID_W-1:0]   boot_ident = BOOT_RESET;

    // what the stimulus generator believes has been written
    logic [ID_W-1:0]   gen_ident [MAX_ENTRIES];
    logic              gen_rtr [MAX_ENTRIES];

    filt_item_t   pending_cmds[$];
    filt_result_t filter_verdicts[$];
    filt_item_t   cur_item;
    filt_result_t want_res;
    int           queued_total = 0;
    int           accepted_total = 0;
    int           mismatches = 0;
    int           idle_odds = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    logic         pressure_go = 1'b0;
    logic         pressure_seen = 1'b0;

    function automatic int live_entries();
        return (entries_cfg > EIU_W'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(entries_cfg);
    endfunction

    function automatic filt_result_t filter_lookup(filt_item_t it);
        filt_result_t     r;
        int               n;
        logic [KEY_W-1:0] key;
        logic             found;
        n = live_entries();
        r.status = ST_NO_MATCH;
        r.index = '0;
        found = 1'b0;
        if (it.cmd == CMD_WRITE) begin
            if (int'(it.entry_index) >= n) begin
                r.status = ST_BAD_INDEX;
            end else begin
                tbl_key[it.entry_index] = {it.filter_rtr, it.filter_ident};
                tbl_mask[it.entry_index] = {1'b1, it.filter_mask};
                tbl_handler[it.entry_index] = 1'b1;
                r.status = ST_WRITTEN;
            end
        end else begin
            key = {it.frame_rtr, it.frame_ident};
            if (it.frame_extended) begin
                r.status = ST_EXTENDED;
            end else if (it.frame_ident == boot_ident) begin
                r.status = ST_BOOTLOADER;
            end else begin
                // first entry in index order wins
                for (int i = 0; i < n; i++) begin
                    if (!found && ((key ^ tbl_key[i]) & tbl_mask[i]) == '0) begin
                        found = 1'b1;
                        r.status = tbl_handler[i] ? ST_MATCH_HANDLER : ST_MATCH_NO_HANDLER;
                        r.index = IDX_W'(i);
                    end
                end
            end
        end
        return r;
    endfunction

    // unused fields of each item kind carry random junk
    function automatic filt_item_t make_write(int idx, logic [ID_W-1:0] ident,
                                              logic [ID_W-1:0] mask, logic rtr);
        filt_item_t it;
        it.cmd = CMD_WRITE;
        it.entry_index = IDX_W'(idx);
        it.filter_ident = ident;
        it.filter_mask = mask;
        it.filter_rtr = rtr;
        it.frame_ident = ID_W'($urandom);
        it.frame_rtr = 1'($urandom);
        it.frame_extended = 1'($urandom);
        return it;
    endfunction

    function automatic filt_item_t make_frame(logic [ID_W-1:0] ident, logic rtr, logic ext);
        filt_item_t it;
        it.cmd = CMD_FRAME;
        it.entry_index = IDX_W'($urandom);
        it.filter_ident = ID_W'($urandom);
        it.filter_mask = ID_W'($urandom);
        it.filter_rtr = 1'($urandom);
        it.frame_ident = ident;
        it.frame_rtr = rtr;
        it.frame_extended = ext;
        return it;
    endfunction

    task automatic push_item(filt_item_t it);
        if (it.cmd == CMD_WRITE && int'(it.entry_index) < live_entries()) begin
            gen_ident[it.entry_index] = it.filter_ident;
            gen_rtr[it.entry_index] = it.filter_rtr;
        end
        pending_cmds.push_back(it);
        queued_total++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ENTRIES_IN_USE)
            entries_cfg = val[EIU_W-1:0];
        else if (idx == CFG_BOOTLOADER_IDENT)
            boot_ident = val;
    endtask

    task automatic set_regs(int count, logic [ID_W-1:0] boot);
        logic [CFG_DATA_W-1:0] val;
        // a write to an unmapped index must be dropped
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
        val = CFG_DATA_W'($urandom);
        val[EIU_W-1:0] = EIU_W'(count);
        write_reg(CFG_ENTRIES_IN_USE, val);
        write_reg(CFG_BOOTLOADER_IDENT, boot);
    endtask

    task automatic wait_quiet();
        while (accepted_total != queued_total || filter_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        int               r;
        int               e;
        int               cap;
        logic [ID_W-1:0]  mask;
        logic [ID_W-1:0]  ident;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            cap = live_entries();
            if (r < 25) begin
                if (cap > 0 && $urandom_range(0, 9) != 0)
                    e = $urandom_range(0, cap - 1);
                else
                    e = $urandom_range(0, 31);
                case ($urandom_range(0, 9))
                    0:       mask = ID_W'($urandom);
                    1, 2, 3: mask = {ID_W{1'b1}} ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                    default: mask = {ID_W{1'b1}};
                endcase
                push_item(make_write(e, ID_W'($urandom), mask, $urandom_range(0, 3) == 0));
            end else if (r < 30) begin
                push_item(make_frame(ID_W'($urandom), 1'($urandom), 1'b1));
            end else if (r < 35) begin
                push_item(make_frame(boot_ident, 1'($urandom), 1'b0));
            end else if (r < 42) begin
                push_item(make_frame(ID_W'($urandom), 1'($urandom), 1'b0));
            end else begin
                // aim at a stored entry, sometimes nudged off it
                e = $urandom_range(0, 31);
                ident = gen_ident[e];
                if ($urandom_range(0, 3) == 0)
                    ident ^= ID_W'(1) << $urandom_range(0, ID_W - 1);
                push_item(make_frame(ident, ($urandom_range(0, 7) == 0) ? !gen_rtr[e] : gen_rtr[e],
                                     1'b0));
            end
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_verdicts.push_back(filter_lookup(cur_item));
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                    gap_left = $urandom_range(0, 9);
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_item = pending_cmds.pop_front();
                    s_cmd <= cur_item.cmd;
                    s_entry_index <= cur_item.entry_index;
                    s_filter_ident <= cur_item.filter_ident;
                    s_filter_mask <= cur_item.filter_mask;
                    s_filter_rtr <= cur_item.filter_rtr;
                    s_frame_ident <= cur_item.frame_ident;
                    s_frame_rtr <= cur_item.frame_rtr;
                    s_frame_extended <= cur_item.frame_extended;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (pressure_go && !pressure_seen) begin
            pressure_seen <= 1'b1;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (filter_verdicts.size() == 0) begin
                $error("unexpected result beat: status %0d, matched_index %0d",
                       m_status, m_matched_index);
                mismatches++;
            end else begin
                want_res = filter_verdicts.pop_front();
                if (m_status !== want_res.status) begin
                    $error("status: expected %0d, actual %0d", want_res.status, m_status);
                    mismatches++;
                end
                if (m_matched_index !== want_res.index) begin
                    $error("matched_index: expected %0d, actual %0d",
                           want_res.index, m_matched_index);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("can_rx_acceptance_filter_core: mismatch");
        $finish;
    end

    initial begin
        int               counts [8];
        int               odds [8];
        logic [ID_W-1:0]  boot;

        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tbl_key[i] = '0;
            tbl_mask[i] = {KEY_W{1'b1}};
            tbl_handler[i] = 1'b0;
            gen_ident[i] = '0;
            gen_rtr[i] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset contents: unwritten entries, bootloader and extended diversion
        idle_odds <= 4;
        push_item(make_frame(11'h000, 1'b0, 1'b0));
        push_item(make_frame(11'h000, 1'b1, 1'b0));
        push_item(make_frame(11'h03C, 1'b1, 1'b0));
        push_item(make_frame(11'h03C, 1'b0, 1'b1));
        push_item(make_frame(11'h7FF, 1'b0, 1'b0));
        push_item(make_write(31, 11'h7FF, 11'h7FF, 1'b1));
        push_item(make_frame(11'h7FF, 1'b1, 1'b0));
        push_item(make_write(0, 11'h000, 11'h000, 1'b0));
        push_item(make_frame(11'h555, 1'b0, 1'b0));
        push_item(make_write(5, 11'h123, 11'h7FF, 1'b0));
        push_item(make_frame(11'h123, 1'b0, 1'b0));
        push_item(make_write(0, 11'h7FF, 11'h7FF, 1'b0));
        push_item(make_frame(11'h123, 1'b0, 1'b0));
        push_item(make_frame(11'h000, 1'b0, 1'b0));
        wait_quiet();

        // single entry, bootloader at identifier zero
        set_regs(1, 11'h000);
        push_item(make_write(1, 11'h2AA, 11'h7FF, 1'b0));
        push_item(make_write(0, 11'h000, 11'h7FF, 1'b0));
        push_item(make_frame(11'h000, 1'b0, 1'b0));
        push_item(make_frame(11'h001, 1'b0, 1'b0));
        push_item(make_frame(11'h7FF, 1'b1, 1'b0));
        wait_quiet();

        // empty table, bootloader at the top identifier
        set_regs(0, 11'h7FF);
        push_item(make_write(0, 11'h100, 11'h7FF, 1'b1));
        push_item(make_frame(11'h123, 1'b0, 1'b0));
        push_item(make_frame(11'h7FF, 1'b1, 1'b0));
        push_item(make_frame(11'h7FF, 1'b0, 1'b1));
        wait_quiet();

        counts = '{32, 63, 33, 1, 16, 0, 32, 32};
        counts[5] = $urandom_range(0, 63);
        odds = '{3, 0, 5, 10, 2, 4, 8, 0};
        for (int p = 0; p < 8; p++) begin
            case (p)
                1:       boot = 11'h000;
                3:       boot = 11'h7FF;
                default: boot = ID_W'($urandom);
            endcase
            set_regs(counts[p], boot);
            idle_odds <= odds[p];
            queue_random(190);
            if (p == 2) begin
                @(posedge aclk);
                pressure_go <= 1'b1;
            end
            wait_quiet();
        end

        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("can_rx_acceptance_filter_core: match");
        else
            $display("can_rx_acceptance_filter_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/can_raf_pkg.sv
sv/can_raf_ram.sv
sv/can_raf_ctrl.sv
sv/can_raf_dp.sv
sv/can_rx_acceptance_filter_core.sv
tb/tb_can_rx_acceptance_filter_core.sv
